[sv/ttg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttg_pkg
// Shared constants, codes and controller/datapath types of the simple glyph
// parser.
// ----------------------------------------------------------------------------
package ttg_pkg;

  localparam int MAX_POINTS = 64;
  localparam int PTR_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // Result kinds
  localparam logic [2:0] KIND_HEADER    = 3'd0;
  localparam logic [2:0] KIND_CONTOUR   = 3'd1;
  localparam logic [2:0] KIND_POINT     = 3'd2;
  localparam logic [2:0] KIND_NO_POINTS = 3'd3;
  localparam logic [2:0] KIND_ERROR     = 3'd4;

  // Flag bit positions
  localparam int FLAG_X_SHORT = 1;
  localparam int FLAG_Y_SHORT = 2;
  localparam int FLAG_REPEAT  = 3;
  localparam int FLAG_X_SAME  = 4;
  localparam int FLAG_Y_SAME  = 5;

  // Last header byte index; the header has ten bytes
  localparam logic [3:0] HDR_LAST = 4'd9;

  typedef enum logic [3:0] {
    ST_HEADER,
    ST_ENDPTS,
    ST_INSTLEN,
    ST_INSTR,
    ST_FLAGS,
    ST_REP_FILL,
    ST_XS_RD,
    ST_XS_CHK,
    ST_XS,
    ST_YS_RD,
    ST_YS_CHK,
    ST_YS,
    ST_ERR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic restart;
    logic hdr_byte;
    logic end_byte;
    logic ilen_byte;
    logic instr_byte;
    logic flag_byte;
    logic rep_step;
    logic x_zero;
    logic x_byte;
    logic y_begin;
    logic y_skip;
    logic y_byte;
    logic err_emit;
  } cmd_t;

  typedef struct packed {
    logic       out_free;
    logic       cnt_odd;
    logic       hdr_last;
    logic       seen_last;
    logic       endpt_big;
    logic       word_zero;
    logic       instr_last;
    logic       total_zero;
    logic       composite;
    logic       rep_pending;
    logic       rep_over;
    logic       rep_zero;
    logic       byte_repeat;
    logic       cursor_end;
    logic       next_end;
    logic [7:0] flag;
  } status_t;

endpackage

[sv/ttg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttg_in_if / ttg_out_if
// Valid/ready channels for record bytes and decoded results.
// ----------------------------------------------------------------------------
interface ttg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       record_start;

  modport source (output valid, output data_byte, output record_start, input ready);
  modport sink   (input valid, input data_byte, input record_start, output ready);
endinterface

interface ttg_out_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  kind;
  logic signed [15:0] contour_count;
  logic signed [15:0] box_min_x;
  logic signed [15:0] box_min_y;
  logic signed [15:0] box_max_x;
  logic signed [15:0] box_max_y;
  logic        [5:0]  item_index;
  logic        [15:0] end_point;
  logic        [7:0]  point_flags;
  logic signed [15:0] x_delta;
  logic signed [15:0] y_delta;
  logic               record_done;

  modport source (output valid, output kind, output contour_count, output box_min_x,
                  output box_min_y, output box_max_x, output box_max_y,
                  output item_index, output end_point, output point_flags,
                  output x_delta, output y_delta, output record_done, input ready);
  modport sink   (input valid, input kind, input contour_count, input box_min_x,
                  input box_min_y, input box_max_x, input box_max_y,
                  input item_index, input end_point, input point_flags,
                  input x_delta, input y_delta, input record_done, output ready);
endinterface

[sv/truetype_simple_glyph_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// truetype_simple_glyph_parser
// Decodes one simple glyph record per byte stream into header, contour end,
// point, no-points and error results.
// ----------------------------------------------------------------------------
// One record byte is taken per cycle while the sequencer is in a byte-taking
// state and the result register is free or being drained. Stalls come from
// the single-port flag and x-delta stores: each repeat run is written out in
// ST_REP_FILL, each x delta passes through a store read (ST_XS_RD) and check
// (ST_XS_CHK) besides its bytes, and every y point passes through a store
// read (ST_YS_RD) and check (ST_YS_CHK) before its bytes or its result. A
// byte with record_start set restarts the parser whenever it is taken; bytes
// after a finished record are dropped without a result.
module truetype_simple_glyph_parser (
  input  logic      clk,
  input  logic      rst,
  ttg_in_if.sink    bytes,
  ttg_out_if.source results
);

  ttg_pkg::cmd_t    cmd;
  ttg_pkg::status_t sts;

  ttg_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (bytes.valid),
    .record_start (bytes.record_start),
    .in_ready     (bytes.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  ttg_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .data_byte     (bytes.data_byte),
    .out_ready     (results.ready),
    .out_valid     (results.valid),
    .kind          (results.kind),
    .contour_count (results.contour_count),
    .box_min_x     (results.box_min_x),
    .box_min_y     (results.box_min_y),
    .box_max_x     (results.box_max_x),
    .box_max_y     (results.box_max_y),
    .item_index    (results.item_index),
    .end_point     (results.end_point),
    .point_flags   (results.point_flags),
    .x_delta       (results.x_delta),
    .y_delta       (results.y_delta),
    .record_done   (results.record_done)
  );

endmodule

[sv/ttg_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttg_ctrl
// Phase sequencer: steps through header, end points, instructions, flags,
// x deltas and y deltas, and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module ttg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             record_start,
  output logic             in_ready,
  input  ttg_pkg::status_t sts,
  output ttg_pkg::cmd_t    cmd
);

  ttg_pkg::state_t state, state_next;
  logic            take;
  logic            byte_state;

  // States that take record bytes
  always_comb begin
    case (state)
      ttg_pkg::ST_HEADER, ttg_pkg::ST_ENDPTS, ttg_pkg::ST_INSTLEN, ttg_pkg::ST_INSTR,
      ttg_pkg::ST_FLAGS, ttg_pkg::ST_XS, ttg_pkg::ST_YS, ttg_pkg::ST_DONE: byte_state = 1'b1;
      default: byte_state = 1'b0;
    endcase
  end

  assign in_ready = byte_state && sts.out_free;
  assign take     = in_ready && in_valid;

  // Next state
  always_comb begin
    state_next = state;
    if (take && record_start) begin
      state_next = ttg_pkg::ST_HEADER;
    end else begin
      case (state)
        ttg_pkg::ST_HEADER: begin
          if (take && sts.cnt_odd && sts.hdr_last) begin
            if (sts.composite) state_next = ttg_pkg::ST_DONE;
            else if (sts.total_zero) state_next = ttg_pkg::ST_INSTLEN;
            else state_next = ttg_pkg::ST_ENDPTS;
          end
        end
        ttg_pkg::ST_ENDPTS: begin
          if (take && sts.cnt_odd && sts.seen_last) begin
            state_next = sts.endpt_big ? ttg_pkg::ST_ERR : ttg_pkg::ST_INSTLEN;
          end
        end
        ttg_pkg::ST_INSTLEN: begin
          if (take && sts.cnt_odd) begin
            if (!sts.word_zero) state_next = ttg_pkg::ST_INSTR;
            else state_next = sts.total_zero ? ttg_pkg::ST_DONE : ttg_pkg::ST_FLAGS;
          end
        end
        ttg_pkg::ST_INSTR: begin
          if (take && sts.instr_last) begin
            state_next = sts.total_zero ? ttg_pkg::ST_DONE : ttg_pkg::ST_FLAGS;
          end
        end
        ttg_pkg::ST_FLAGS: begin
          if (take) begin
            if (sts.rep_pending) begin
              state_next = sts.rep_over ? ttg_pkg::ST_DONE : ttg_pkg::ST_REP_FILL;
            end else if (!sts.byte_repeat && sts.next_end) begin
              state_next = ttg_pkg::ST_XS_RD;
            end
          end
        end
        ttg_pkg::ST_REP_FILL: begin
          if (sts.rep_zero) begin
            state_next = sts.cursor_end ? ttg_pkg::ST_XS_RD : ttg_pkg::ST_FLAGS;
          end
        end
        ttg_pkg::ST_XS_RD: begin
          state_next = sts.cursor_end ? ttg_pkg::ST_YS_RD : ttg_pkg::ST_XS_CHK;
        end
        ttg_pkg::ST_XS_CHK: begin
          if (sts.flag[ttg_pkg::FLAG_X_SHORT] || !sts.flag[ttg_pkg::FLAG_X_SAME]) begin
            state_next = ttg_pkg::ST_XS;
          end else begin
            state_next = ttg_pkg::ST_XS_RD;
          end
        end
        ttg_pkg::ST_XS: begin
          if (take && (sts.flag[ttg_pkg::FLAG_X_SHORT] || sts.cnt_odd)) begin
            state_next = ttg_pkg::ST_XS_RD;
          end
        end
        ttg_pkg::ST_YS_RD: begin
          state_next = ttg_pkg::ST_YS_CHK;
        end
        ttg_pkg::ST_YS_CHK: begin
          if (sts.flag[ttg_pkg::FLAG_Y_SHORT] || !sts.flag[ttg_pkg::FLAG_Y_SAME]) begin
            state_next = ttg_pkg::ST_YS;
          end else if (sts.out_free) begin
            state_next = sts.next_end ? ttg_pkg::ST_DONE : ttg_pkg::ST_YS_RD;
          end
        end
        ttg_pkg::ST_YS: begin
          if (take && (sts.flag[ttg_pkg::FLAG_Y_SHORT] || sts.cnt_odd)) begin
            state_next = sts.next_end ? ttg_pkg::ST_DONE : ttg_pkg::ST_YS_RD;
          end
        end
        ttg_pkg::ST_ERR: begin
          if (sts.out_free) state_next = ttg_pkg::ST_DONE;
        end
        ttg_pkg::ST_DONE: begin
          state_next = ttg_pkg::ST_DONE;
        end
        default: state_next = ttg_pkg::ST_HEADER;
      endcase
    end
  end

  // Commands
  always_comb begin
    logic op;
    op = take && !record_start;
    cmd            = '0;
    cmd.restart    = take && record_start;
    case (state)
      ttg_pkg::ST_HEADER:   cmd.hdr_byte   = op;
      ttg_pkg::ST_ENDPTS:   cmd.end_byte   = op;
      ttg_pkg::ST_INSTLEN:  cmd.ilen_byte  = op;
      ttg_pkg::ST_INSTR:    cmd.instr_byte = op;
      ttg_pkg::ST_FLAGS:    cmd.flag_byte  = op;
      ttg_pkg::ST_REP_FILL: cmd.rep_step   = 1'b1;
      ttg_pkg::ST_XS_RD:    cmd.y_begin    = sts.cursor_end;
      ttg_pkg::ST_XS_CHK:
        cmd.x_zero = !sts.flag[ttg_pkg::FLAG_X_SHORT] && sts.flag[ttg_pkg::FLAG_X_SAME];
      ttg_pkg::ST_XS:       cmd.x_byte     = op;
      ttg_pkg::ST_YS_CHK:
        cmd.y_skip = !sts.flag[ttg_pkg::FLAG_Y_SHORT] && sts.flag[ttg_pkg::FLAG_Y_SAME]
                     && sts.out_free;
      ttg_pkg::ST_YS:       cmd.y_byte     = op;
      ttg_pkg::ST_ERR:      cmd.err_emit   = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttg_pkg::ST_HEADER;
    end else begin
      state <= state_next;
    end
  end

endmodule

[sv/ttg_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttg_datapath
// Field registers, flag and x-delta stores, and the result register.
// ----------------------------------------------------------------------------
module ttg_datapath (
  input  logic                clk,
  input  logic                rst,
  input  ttg_pkg::cmd_t       cmd,
  output ttg_pkg::status_t    sts,
  input  logic [7:0]          data_byte,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [2:0]          kind,
  output logic signed [15:0]  contour_count,
  output logic signed [15:0]  box_min_x,
  output logic signed [15:0]  box_min_y,
  output logic signed [15:0]  box_max_x,
  output logic signed [15:0]  box_max_y,
  output logic [5:0]          item_index,
  output logic [15:0]         end_point,
  output logic [7:0]          point_flags,
  output logic signed [15:0]  x_delta,
  output logic signed [15:0]  y_delta,
  output logic                record_done
);

  localparam int PW = ttg_pkg::PTR_W;
  localparam int CW = ttg_pkg::CNT_W;

  logic [3:0]    cnt;
  logic [7:0]    hold;
  logic [15:0]   ctotal;
  logic [15:0]   seen;
  logic [CW-1:0] ptotal;
  logic [CW-1:0] cursor;
  logic          rep_pending;
  logic [7:0]    rep_count;
  logic [7:0]    last_flag;
  logic [15:0]   remaining;
  logic [15:0]   box [4];

  logic [7:0]    flag_mem [ttg_pkg::MAX_POINTS];
  logic [15:0]   x_mem    [ttg_pkg::MAX_POINTS];
  logic [7:0]    flag_q;
  logic [15:0]   x_q;

  logic [15:0]   word;
  logic [15:0]   x_short;
  logic [15:0]   y_short;
  logic [CW-1:0] cursor_inc;
  logic          fl_we;
  logic [7:0]    fl_wd;
  logic          x_we;
  logic [15:0]   x_wd;

  // Emission
  logic          emit;
  logic [2:0]    e_kind;
  logic          e_hdr;
  logic [5:0]    e_item;
  logic [15:0]   e_endp;
  logic          e_point;
  logic [15:0]   e_y;
  logic          e_done;

  assign word       = {hold, data_byte};
  assign cursor_inc = cursor + CW'(1);
  assign x_short    = flag_q[ttg_pkg::FLAG_X_SAME] ? {8'd0, data_byte}
                                                   : 16'd0 - {8'd0, data_byte};
  assign y_short    = flag_q[ttg_pkg::FLAG_Y_SAME] ? {8'd0, data_byte}
                                                   : 16'd0 - {8'd0, data_byte};

  // Status toward the sequencer
  always_comb begin
    sts             = '0;
    sts.out_free    = !out_valid || out_ready;
    sts.cnt_odd     = cnt[0];
    sts.hdr_last    = (cnt == ttg_pkg::HDR_LAST);
    sts.seen_last   = ({1'b0, seen} + 17'd1) >= {1'b0, ctotal};
    sts.endpt_big   = ({1'b0, word} + 17'd1) > 17'(ttg_pkg::MAX_POINTS);
    sts.word_zero   = (word == 16'd0);
    sts.instr_last  = (remaining == 16'd1);
    sts.total_zero  = (ctotal == 16'd0);
    sts.composite   = ctotal[15];
    sts.rep_pending = rep_pending;
    sts.rep_over    = ({2'b00, cursor} + {1'b0, data_byte}) > {2'b00, ptotal};
    sts.rep_zero    = (rep_count == 8'd0);
    sts.byte_repeat = data_byte[ttg_pkg::FLAG_REPEAT];
    sts.cursor_end  = (cursor >= ptotal);
    sts.next_end    = ({1'b0, cursor} + 8'd1) >= {1'b0, ptotal};
    sts.flag        = flag_q;
  end

  // Store write controls
  assign fl_we = (cmd.flag_byte && !rep_pending) || (cmd.rep_step && rep_count != 8'd0);
  assign fl_wd = cmd.rep_step ? last_flag : data_byte;
  assign x_we  = cmd.x_zero
              || (cmd.x_byte && (flag_q[ttg_pkg::FLAG_X_SHORT] || cnt[0]));
  assign x_wd  = cmd.x_zero ? 16'd0
               : (flag_q[ttg_pkg::FLAG_X_SHORT] ? x_short : word);

  always_ff @(posedge clk) begin
    if (fl_we) flag_mem[cursor[PW-1:0]] <= fl_wd;
    flag_q <= flag_mem[cursor[PW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (x_we) x_mem[cursor[PW-1:0]] <= x_wd;
    x_q <= x_mem[cursor[PW-1:0]];
  end

  // Pick the result to emit this cycle
  always_comb begin
    emit    = 1'b0;
    e_kind  = ttg_pkg::KIND_ERROR;
    e_hdr   = 1'b0;
    e_item  = '0;
    e_endp  = '0;
    e_point = 1'b0;
    e_y     = '0;
    e_done  = 1'b0;
    if (cmd.hdr_byte && cnt[0] && cnt == ttg_pkg::HDR_LAST) begin
      emit   = 1'b1;
      e_kind = ttg_pkg::KIND_HEADER;
      e_hdr  = 1'b1;
      e_done = ctotal[15];
    end else if (cmd.end_byte && cnt[0]) begin
      emit   = 1'b1;
      e_kind = ttg_pkg::KIND_CONTOUR;
      e_item = seen[5:0];
      e_endp = word;
    end else if ((cmd.ilen_byte && cnt[0] && word == 16'd0 && ctotal == 16'd0)
              || (cmd.instr_byte && remaining == 16'd1 && ctotal == 16'd0)) begin
      emit   = 1'b1;
      e_kind = ttg_pkg::KIND_NO_POINTS;
      e_done = 1'b1;
    end else if ((cmd.flag_byte && rep_pending && sts.rep_over) || cmd.err_emit) begin
      emit   = 1'b1;
      e_kind = ttg_pkg::KIND_ERROR;
      e_done = 1'b1;
    end else if (cmd.y_skip
              || (cmd.y_byte && (flag_q[ttg_pkg::FLAG_Y_SHORT] || cnt[0]))) begin
      emit    = 1'b1;
      e_kind  = ttg_pkg::KIND_POINT;
      e_point = 1'b1;
      e_item  = cursor[5:0];
      e_done  = sts.next_end;
      if (cmd.y_byte) e_y = flag_q[ttg_pkg::FLAG_Y_SHORT] ? y_short : word;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      kind          <= e_kind;
      contour_count <= e_hdr ? ctotal : 16'd0;
      box_min_x     <= e_hdr ? box[0] : 16'd0;
      box_min_y     <= e_hdr ? box[1] : 16'd0;
      box_max_x     <= e_hdr ? box[2] : 16'd0;
      box_max_y     <= e_hdr ? word : 16'd0;
      item_index    <= e_item;
      end_point     <= e_endp;
      point_flags   <= e_point ? flag_q : 8'd0;
      x_delta       <= e_point ? x_q : 16'd0;
      y_delta       <= e_y;
      record_done   <= e_done;
    end
  end

  // Field registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      hold        <= '0;
      ctotal      <= '0;
      seen        <= '0;
      ptotal      <= '0;
      cursor      <= '0;
      rep_pending <= 1'b0;
      rep_count   <= '0;
      last_flag   <= '0;
      remaining   <= '0;
      for (int i = 0; i < 4; i++) box[i] <= '0;
    end else if (cmd.restart) begin
      // First byte of a new record: high byte of the contour count
      hold        <= data_byte;
      cnt         <= 4'd1;
      ctotal      <= '0;
      seen        <= '0;
      rep_pending <= 1'b0;
      rep_count   <= '0;
      for (int i = 0; i < 4; i++) box[i] <= '0;
    end else begin
      if (cmd.hdr_byte) begin
        if (!cnt[0]) begin
          hold <= data_byte;
          cnt  <= cnt + 4'd1;
        end else begin
          if (cnt == 4'd1) ctotal <= word;
          else box[2'(cnt[3:1] - 3'd1)] <= word;
          if (cnt == ttg_pkg::HDR_LAST) begin
            cnt  <= '0;
            seen <= '0;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
      end

      if (cmd.end_byte) begin
        if (!cnt[0]) begin
          hold <= data_byte;
          cnt  <= 4'd1;
        end else begin
          cnt  <= '0;
          seen <= seen + 16'd1;
          if (sts.seen_last && !sts.endpt_big) ptotal <= CW'(word + 16'd1);
        end
      end

      // Instruction length, then skip that many bytes
      if (cmd.ilen_byte) begin
        if (!cnt[0]) begin
          hold <= data_byte;
          cnt  <= 4'd1;
        end else begin
          cnt       <= '0;
          remaining <= word;
          if (word == 16'd0) begin
            cursor      <= '0;
            rep_pending <= 1'b0;
          end
        end
      end
      if (cmd.instr_byte) begin
        remaining <= remaining - 16'd1;
        if (remaining == 16'd1) begin
          cursor      <= '0;
          rep_pending <= 1'b0;
        end
      end

      // Flags and repeat runs
      if (cmd.flag_byte) begin
        if (rep_pending) begin
          rep_pending <= 1'b0;
          rep_count   <= data_byte;
        end else begin
          last_flag <= data_byte;
          if (data_byte[ttg_pkg::FLAG_REPEAT]) begin
            rep_pending <= 1'b1;
            cursor      <= cursor_inc;
          end else if (sts.next_end) begin
            cursor <= '0;
            cnt    <= '0;
          end else begin
            cursor <= cursor_inc;
          end
        end
      end
      if (cmd.rep_step) begin
        if (rep_count != 8'd0) begin
          rep_count <= rep_count - 8'd1;
          cursor    <= cursor_inc;
        end else if (sts.cursor_end) begin
          cursor <= '0;
          cnt    <= '0;
        end
      end

      // X deltas
      if (cmd.x_zero) cursor <= cursor_inc;
      if (cmd.x_byte) begin
        if (flag_q[ttg_pkg::FLAG_X_SHORT]) begin
          cursor <= cursor_inc;
        end else if (!cnt[0]) begin
          hold <= data_byte;
          cnt  <= 4'd1;
        end else begin
          cnt    <= '0;
          cursor <= cursor_inc;
        end
      end

      // Y deltas
      if (cmd.y_begin) begin
        cursor <= '0;
        cnt    <= '0;
      end
      if (cmd.y_skip) cursor <= cursor_inc;
      if (cmd.y_byte) begin
        if (flag_q[ttg_pkg::FLAG_Y_SHORT]) begin
          cursor <= cursor_inc;
        end else if (!cnt[0]) begin
          hold <= data_byte;
          cnt  <= 4'd1;
        end else begin
          cnt    <= '0;
          cursor <= cursor_inc;
        end
      end
    end
  end

endmodule
